// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/apsp_pkg.sv -----
// ----------------------------------------------------------------------------
// apsp_pkg
// types and constants of the all-pairs shortest path core
// ----------------------------------------------------------------------------
`default_nettype none

package apsp_pkg;

    localparam int MAX_NODE_COUNT = 64;
    localparam int IDX_W          = $clog2(MAX_NODE_COUNT);
    localparam int ADDR_W         = 2 * IDX_W;
    localparam int CNT_W          = 7;
    localparam int DIST_W         = 24;
    localparam int WEIGHT_W       = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [5:0]                 row;
        logic [5:0]                 col;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       no_edge;
    } in_beat_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     unreachable;
    } out_beat_t;

    // one stored matrix entry: flag plus distance
    typedef struct packed {
        logic                     inf;
        logic signed [DIST_W-1:0] cost;
    } entry_t;

endpackage

`default_nettype wire

// ----- design/all_pairs_shortest_path_core.sv -----
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// floyd-warshall closure over a dense distance matrix held in one memory
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------
//  in       | in_valid / in_stall | in_data  (cmd row col weight no_edge)
//  out      | out_valid/out_stall | out_data (distance unreachable)
//  cfg      | cfg_we              | cfg_wdata (node_count)
//
//  write beat: result shown the cycle after acceptance; read beat: memory
//  read register, then ST_RD_WAIT; run beat: per pivot ST_PIV_RD/ST_PIV_WR
//  per column, per row ST_ROW_RD/ST_ROW_LD, per relaxation ST_REL_RD and
//  ST_REL_CMP, then ST_DONE; run time is set by the single read port of
//  the distance memory and the shared add / clamp / compare unit
//  reset clears control and node_count (to 1); the memory is not cleared
//  in_stall stays high while a beat is at work or a result is held back
`default_nettype none

module all_pairs_shortest_path_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire apsp_pkg::in_beat_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output apsp_pkg::out_beat_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [apsp_pkg::CNT_W-1:0] cfg_wdata
);

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_WAIT = 4'd1;  // read beat, memory data on the way
    localparam logic [3:0] ST_PIV_RD  = 4'd2;  // fetch pivot row entry k,j
    localparam logic [3:0] ST_PIV_WR  = 4'd3;  // copy it into the pivot buffer
    localparam logic [3:0] ST_ROW_RD  = 4'd4;  // fetch entry i,k
    localparam logic [3:0] ST_ROW_LD  = 4'd5;  // latch entry i,k
    localparam logic [3:0] ST_REL_RD  = 4'd6;  // fetch entry i,j and pivot j
    localparam logic [3:0] ST_REL_CMP = 4'd7;  // add, clamp, compare, write back
    localparam logic [3:0] ST_DONE    = 4'd8;  // run finished, post zero result

    localparam int IDX_W  = apsp_pkg::IDX_W;
    localparam int ADDR_W = apsp_pkg::ADDR_W;
    localparam int CNT_W  = apsp_pkg::CNT_W;
    localparam int DIST_W = apsp_pkg::DIST_W;

    // distance matrix and the snapshot of pivot row k
    apsp_pkg::entry_t store_mem [apsp_pkg::MAX_NODE_COUNT * apsp_pkg::MAX_NODE_COUNT];
    apsp_pkg::entry_t pivot_mem [apsp_pkg::MAX_NODE_COUNT];

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    node_count_reg;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    apsp_pkg::entry_t    ik_reg, ik_next;
    logic                out_valid_reg, out_valid_next;
    apsp_pkg::out_beat_t out_data_reg, out_data_next;

    apsp_pkg::entry_t    store_rdata_reg;
    apsp_pkg::entry_t    piv_rdata_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    apsp_pkg::entry_t    mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                piv_we;

    logic                in_accept;
    logic [CNT_W-1:0]    n_eff;
    logic                j_last, i_last, k_last;

    // shared relaxation unit
    logic signed [DIST_W:0]   sum_wide;
    logic signed [DIST_W-1:0] sum_clamp;
    logic                     relax_ok;
    logic                     relax_upd;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // node counts above the matrix size fall back to the full matrix
    assign n_eff = (node_count_reg > CNT_W'(apsp_pkg::MAX_NODE_COUNT))
                 ? CNT_W'(apsp_pkg::MAX_NODE_COUNT) : node_count_reg;

    assign j_last = ({1'b0, j_reg} == n_reg - 1'b1);
    assign i_last = ({1'b0, i_reg} == n_reg - 1'b1);
    assign k_last = ({1'b0, k_reg} == n_reg - 1'b1);

    // d(i,k) + d(k,j), saturated to the signed distance range
    always_comb
    begin
        sum_wide = {ik_reg.cost[DIST_W-1], ik_reg.cost}
                 + {piv_rdata_reg.cost[DIST_W-1], piv_rdata_reg.cost};
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1])
        begin
            sum_clamp = sum_wide[DIST_W] ? apsp_pkg::DIST_MIN : apsp_pkg::DIST_MAX;
        end
        else
        begin
            sum_clamp = sum_wide[DIST_W-1:0];
        end
        // a path through an unreachable entry is skipped
        relax_ok  = !ik_reg.inf && !piv_rdata_reg.inf;
        relax_upd = relax_ok && (store_rdata_reg.inf || (sum_clamp < store_rdata_reg.cost));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ik_next        = ik_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = {i_reg, j_reg};
        mem_wdata      = '{inf: 1'b0, cost: sum_clamp};
        mem_raddr      = {in_data.row, in_data.col};
        piv_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_data.cmd)
                        apsp_pkg::CMD_WRITE:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = {in_data.row, in_data.col};
                            mem_wdata.inf  = in_data.no_edge;
                            mem_wdata.cost = in_data.no_edge ? '0
                                : {{(DIST_W-apsp_pkg::WEIGHT_W){in_data.weight[apsp_pkg::WEIGHT_W-1]}},
                                   in_data.weight};
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                        apsp_pkg::CMD_READ:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        apsp_pkg::CMD_RUN:
                        begin
                            if (n_eff == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                            end
                            else
                            begin
                                n_next     = n_eff;
                                k_next     = '0;
                                j_next     = '0;
                                state_next = ST_PIV_RD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                out_valid_next            = 1'b1;
                out_data_next.unreachable = store_rdata_reg.inf;
                out_data_next.distance    = store_rdata_reg.inf ? '0 : store_rdata_reg.cost;
                state_next                = ST_IDLE;
            end

            ST_PIV_RD:
            begin
                mem_raddr  = {k_reg, j_reg};
                state_next = ST_PIV_WR;
            end

            ST_PIV_WR:
            begin
                piv_we = 1'b1;
                if (j_last)
                begin
                    j_next     = '0;
                    i_next     = '0;
                    state_next = ST_ROW_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_PIV_RD;
                end
            end

            ST_ROW_RD:
            begin
                mem_raddr  = {i_reg, k_reg};
                state_next = ST_ROW_LD;
            end

            ST_ROW_LD:
            begin
                ik_next    = store_rdata_reg;
                j_next     = '0;
                state_next = ST_REL_RD;
            end

            ST_REL_RD:
            begin
                mem_raddr  = {i_reg, j_reg};
                state_next = ST_REL_CMP;
            end

            ST_REL_CMP:
            begin
                if (relax_upd)
                begin
                    mem_we = 1'b1;
                    // entry i,k itself changed: later columns see the new value
                    if (j_reg == k_reg)
                    begin
                        ik_next = '{inf: 1'b0, cost: sum_clamp};
                    end
                end
                if (!j_last)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_REL_RD;
                end
                else if (!i_last)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW_RD;
                end
                else if (!k_last)
                begin
                    k_next     = k_reg + 1'b1;
                    j_next     = '0;
                    state_next = ST_PIV_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        store_rdata_reg <= store_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (piv_we)
        begin
            pivot_mem[j_reg] <= store_rdata_reg;
        end
        piv_rdata_reg <= pivot_mem[j_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            node_count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    // counters and payload
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        ik_reg       <= ik_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- design/apsp_checker.sv -----
// ----------------------------------------------------------------------------
// apsp_checker
// port-level checks of the all-pairs shortest path core
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module apsp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire apsp_pkg::in_beat_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire apsp_pkg::out_beat_t out_data
);

    // held result beat stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "held result beat changed")

    // a write beat answers zero on the next cycle
    `ASSERT_NEXT(a_write_result, clk, rst_n, in_valid && !in_stall && in_data.cmd == apsp_pkg::CMD_WRITE, out_valid && out_data.distance == '0 && !out_data.unreachable, "write beat result wrong")

    // a read beat holds in_stall high, then shows its result
    `ASSERT_IMPL(a_read_latency, clk, rst_n, in_valid && !in_stall && in_data.cmd == apsp_pkg::CMD_READ, ##1 in_stall ##1 out_valid, "read beat latency wrong")

    // infinite entries read as zero distance
    `ASSERT_IMPL(a_inf_zero, clk, rst_n, out_valid && out_data.unreachable, out_data.distance == '0, "unreachable beat with nonzero distance")

endmodule

bind all_pairs_shortest_path_core apsp_checker u_apsp_checker (.*);

`default_nettype wire
